// ----- rtl/key_matrix_debouncer_macros.svh -----
// Assertion macros shared by the key matrix debouncer RTL.
// Bodies sample on clk and are disabled while rst is high; no other dependencies.
`ifndef KEY_MATRIX_DEBOUNCER_MACROS_SVH
`define KEY_MATRIX_DEBOUNCER_MACROS_SVH

// Same-cycle implication
`define KMD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key_matrix_debouncer: implication check failed");

// Next-cycle implication
`define KMD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key_matrix_debouncer: next-cycle check failed");

`endif

// ----- rtl/kmd_pkg.sv -----
// Shared types and constants for the key matrix debouncer.
// No dependencies; used by key_matrix_debouncer.
package kmd_pkg;

  localparam int ROW_W   = 3;
  localparam int COL_W   = 4;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd100;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

  // Per-key entry: only the count of the last sampled level can be nonzero,
  // so one count plus the last level stands for both press and release counts.
  typedef struct packed {
    logic               down;
    logic               level;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

// ----- rtl/key_matrix_debouncer.sv -----
// Key matrix debouncer: one raw key sample in per transfer, one debounced
// result (key_down, changed) out per sample. Takes one sample every clock cycle
// unless the result stream stalls or the RAM is being cleared; a result passes
// the memory read stage, then the output register. Per-key state lives in one RAM of
// ROWS*COLUMNS entries, read-modify-write with forwarding of the previous cycle's
// write. After reset the RAM is cleared in a pass over all ROWS*COLUMNS entries,
// during which s_tready is low; cfg writes are taken at any time. Samples of keys
// outside the matrix give key_down = 0, changed = 0 and leave the state alone.
// Depends on kmd_pkg, kmd_ram and key_matrix_debouncer_macros.svh.
module key_matrix_debouncer #(
  parameter int ROWS    = 5,
  parameter int COLUMNS = 15
) (
  input  logic       clk,
  input  logic       rst,
  // Sample stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [2:0] row_index, [6:3] column_index, [7] pressed
  // Result stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] key_down, [1] changed, [7:2] zero
  // Threshold register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data  // debounce_threshold
);

  `include "key_matrix_debouncer_macros.svh"

  localparam int KEYS    = ROWS * COLUMNS;
  localparam int KEY_AW  = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int ENTRY_W = $bits(kmd_pkg::entry_t);
  localparam logic [KEY_AW-1:0] LAST_KEY = KEY_AW'(KEYS - 1);

  // Threshold register
  logic [kmd_pkg::COUNT_W-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= kmd_pkg::THRESHOLD_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // Clearing pass after reset
  logic              clr_active;
  logic [KEY_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == LAST_KEY) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + KEY_AW'(1);
    end
  end

  // Input decode
  logic [kmd_pkg::ROW_W-1:0] in_row;
  logic [kmd_pkg::COL_W-1:0] in_col;
  logic                      in_level;
  logic                      in_ok;
  logic [KEY_AW-1:0]         in_key;
  logic                      accept;

  assign in_row   = s_tdata[2:0];
  assign in_col   = s_tdata[6:3];
  assign in_level = s_tdata[7];
  assign in_ok    = (32'(in_row) < ROWS) && (32'(in_col) < COLUMNS);
  assign in_key   = KEY_AW'(in_row) * KEY_AW'(COLUMNS) + KEY_AW'(in_col);

  // Stage 1: memory data arrives, entry is updated
  logic                        s1_valid;
  logic                        s1_ok;
  logic                        s1_level;
  logic [KEY_AW-1:0]           s1_key;
  logic                        s1_fwd;
  kmd_pkg::entry_t             s1_fwd_data;
  logic                        s1_adv;

  // Output register
  logic o_valid;
  logic o_down;
  logic o_changed;

  assign s1_adv   = !o_valid || m_tready;
  assign s_tready = !clr_active && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // Memory ports
  logic                upd_we;
  kmd_pkg::entry_t     upd_entry;
  logic                ram_we;
  logic [KEY_AW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  assign upd_we    = s1_valid && s1_ok && s1_adv;
  assign ram_we    = clr_active || upd_we;
  assign ram_waddr = clr_active ? clr_addr : s1_key;
  assign ram_wdata = clr_active ? '0 : upd_entry;

  kmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEYS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (in_key),
    .rd_data (ram_rdata)
  );

  // Stage 1 registers; forward the write that lands at the read edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok       <= in_ok;
      s1_level    <= in_level;
      s1_key      <= in_key;
      s1_fwd      <= upd_we && (s1_key == in_key);
      s1_fwd_data <= upd_entry;
    end
  end

  // Entry update
  kmd_pkg::entry_t             cur;
  logic [kmd_pkg::COUNT_W-1:0] old_count;
  logic                        new_down;

  always_comb begin
    cur       = s1_fwd ? s1_fwd_data : kmd_pkg::entry_t'(ram_rdata);
    old_count = (cur.level == s1_level) ? cur.count : '0;
    new_down  = (old_count >= threshold) ? s1_level : cur.down;
    upd_entry.down  = new_down;
    upd_entry.level = s1_level;
    upd_entry.count = (old_count == kmd_pkg::COUNT_MAX) ? kmd_pkg::COUNT_MAX
                                                        : old_count + 16'd1;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      o_down    <= s1_ok && new_down;
      o_changed <= s1_ok && (new_down != cur.down);
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {6'b000000, o_changed, o_down};

  // Checks
  `KMD_ASSERT_IMP(a_no_update_in_clear, clr_active, !upd_we)
  `KMD_ASSERT_NEXT(a_clear_stays_done, !clr_active, !clr_active)
  `KMD_ASSERT_NEXT(a_fwd_same_key, accept && upd_we && (s1_key == in_key), s1_fwd)
  `KMD_ASSERT_NEXT(a_outside_key_zero, s1_valid && !s1_ok && s1_adv,
                   !o_down && !o_changed)

endmodule

// ----- rtl/kmd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kmd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 75
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- tb/key_matrix_debouncer_tb.sv -----
// Self-checking testbench for key_matrix_debouncer: a directed table, a largest-threshold
// run and randomized key runs, scored against typed table results or a per-key predictor.
// Depends on kmd_pkg and the key_matrix_debouncer RTL.
module key_matrix_debouncer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS         = 5;
  localparam int COLUMNS      = 15;
  localparam int KEYS         = ROWS * COLUMNS;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int PHASE_ITEMS  = 400;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_THR_RUN  = 12;

  typedef struct packed {
    logic                      pressed;
    logic [kmd_pkg::COL_W-1:0] column;
    logic [kmd_pkg::ROW_W-1:0] row;
  } sample_t;

  typedef struct packed {
    logic key_down;
    logic changed;
  } verdict_t;

  typedef enum logic {STEP_SAMPLE, STEP_THRESHOLD} step_kind_t;

  typedef struct packed {
    step_kind_t                  kind;
    logic [kmd_pkg::ROW_W-1:0]   row;
    logic [kmd_pkg::COL_W-1:0]   column;
    logic                        pressed;
    logic [kmd_pkg::COUNT_W-1:0] thr;
    logic                        typed;
    logic                        key_down;
    logic                        changed;
  } dir_step_t;

  // Directed table: typed results only where they are obvious
  localparam int DIR_STEPS = 26;
  localparam dir_step_t DIRECTED [DIR_STEPS] = '{
    // default threshold after reset: nothing can go down yet
    '{STEP_SAMPLE,    3'd0, 4'd0,  1'b1, 16'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b0, 16'd0, 1'b1, 1'b0, 1'b0},
    // keys outside the matrix
    '{STEP_SAMPLE,    3'd5, 4'd0,  1'b1, 16'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd7, 4'd15, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd0, 4'd15, 1'b1, 16'd0, 1'b1, 1'b0, 1'b0},
    // zero threshold: state follows every sample
    '{STEP_THRESHOLD, 3'd0, 4'd0,  1'b0, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd0, 4'd0,  1'b1, 16'd0, 1'b1, 1'b1, 1'b1},
    '{STEP_SAMPLE,    3'd0, 4'd0,  1'b1, 16'd0, 1'b1, 1'b1, 1'b0},
    '{STEP_SAMPLE,    3'd0, 4'd0,  1'b0, 16'd0, 1'b1, 1'b0, 1'b1},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b1, 16'd0, 1'b1, 1'b1, 1'b1},
    '{STEP_SAMPLE,    3'd6, 4'd3,  1'b1, 16'd0, 1'b1, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd2, 4'd9,  1'b1, 16'd0, 1'b1, 1'b1, 1'b1},
    // threshold two: release with a bounce, then press again
    '{STEP_THRESHOLD, 3'd0, 4'd0,  1'b0, 16'd2, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd4, 4'd14, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0},
    // threshold one
    '{STEP_THRESHOLD, 3'd0, 4'd0,  1'b0, 16'd1, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd3, 4'd5,  1'b1, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd3, 4'd5,  1'b1, 16'd0, 1'b0, 1'b0, 1'b0},
    '{STEP_SAMPLE,    3'd3, 4'd5,  1'b0, 16'd0, 1'b0, 1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [2:0] row_index, [6:3] column_index, [7] pressed
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;    // [0] key_down, [1] changed, [7:2] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;   // debounce_threshold

  // Predictor state
  logic [kmd_pkg::COUNT_W-1:0] press_run   [KEYS];
  logic [kmd_pkg::COUNT_W-1:0] release_run [KEYS];
  logic                        key_is_down [KEYS];
  logic [kmd_pkg::COUNT_W-1:0] threshold;

  verdict_t    expected_verdicts [$];
  int unsigned failures     = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  int unsigned hold_left    = 0;
  bit          held_off     = 1'b0;

  key_matrix_debouncer #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6ns clk = 1'b1;
    #6ns clk = 1'b0;
  end

  // Debounced state after one sample; updates the per-key counts
  function automatic verdict_t debounce_predict(input sample_t s);
    verdict_t    v;
    int unsigned key;
    logic        prior;
    v = '0;
    if (s.row >= ROWS || s.column >= COLUMNS) return v;
    key   = s.row * COLUMNS + s.column;
    prior = key_is_down[key];
    if (s.pressed) begin
      release_run[key] = '0;
      if (press_run[key] >= threshold) key_is_down[key] = 1'b1;
      if (press_run[key] != kmd_pkg::COUNT_MAX) begin
        press_run[key] = press_run[key] + 1'b1;
      end
    end else begin
      press_run[key] = '0;
      if (release_run[key] >= threshold) key_is_down[key] = 1'b0;
      if (release_run[key] != kmd_pkg::COUNT_MAX) begin
        release_run[key] = release_run[key] + 1'b1;
      end
    end
    v.key_down = key_is_down[key];
    v.changed  = key_is_down[key] != prior;
    return v;
  endfunction

  // Offer one sample in bursts with random gaps; called at a falling edge
  task automatic offer(input sample_t s, input bit typed, input verdict_t typed_v);
    verdict_t predicted;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid = 1'b1;
    s_tdata  = s;
    do @(posedge clk); while (!s_tready);
    predicted = debounce_predict(s);
    expected_verdicts.push_back(typed ? typed_v : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // Let every result arrive, then the pipeline settle
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [kmd_pkg::COUNT_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    threshold = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: rotating stall patterns plus one long hold-off
  always @(negedge clk) begin
    int unsigned mode;
    mode = (cycle_count / 97) % 4;
    if (hold_left != 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else if (!held_off && results_seen >= HOLD_AT) begin
      held_off  = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready  = 1'b0;
    end else begin
      case (mode)
        0: m_tready = 1'b1;
        1: m_tready = $urandom_range(0, 3) != 0;
        2: m_tready = $urandom_range(0, 4) < 2;
        default: m_tready = cycle_count[1:0] != 2'b11;
      endcase
    end
  end

  // Result scoreboard
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result transfer, m_tdata %02h", m_tdata);
        failures++;
      end else begin
        want = expected_verdicts.pop_front();
        if (m_tdata[0] !== want.key_down) begin
          $error("key_down: expected %0b, actual %0b", want.key_down, m_tdata[0]);
          failures++;
        end
        if (m_tdata[1] !== want.changed) begin
          $error("changed: expected %0b, actual %0b", want.changed, m_tdata[1]);
          failures++;
        end
        if (m_tdata[7:2] !== 6'd0) begin
          $error("pad: expected 0, actual %0h", m_tdata[7:2]);
          failures++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("key_matrix_debouncer regression: fail");
      $finish;
    end
  end

  initial begin
    sample_t     s;
    verdict_t    typed_v;
    logic        level;
    bit          bounce;
    int unsigned run_len;
    int unsigned sent;
    logic [kmd_pkg::ROW_W-1:0] run_row;
    logic [kmd_pkg::COL_W-1:0] run_col;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    threshold = kmd_pkg::THRESHOLD_RESET;
    for (int k = 0; k < KEYS; k++) begin
      press_run[k]   = '0;
      release_run[k] = '0;
      key_is_down[k] = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int i = 0; i < DIR_STEPS; i++) begin
      if (DIRECTED[i].kind == STEP_THRESHOLD) begin
        write_threshold(DIRECTED[i].thr);
      end else begin
        s.row     = DIRECTED[i].row;
        s.column  = DIRECTED[i].column;
        s.pressed = DIRECTED[i].pressed;
        typed_v.key_down = DIRECTED[i].key_down;
        typed_v.changed  = DIRECTED[i].changed;
        offer(s, DIRECTED[i].typed, typed_v);
      end
    end

    // Largest threshold: a held key never reaches it
    write_threshold(kmd_pkg::COUNT_MAX);
    s.row    = 3'd1;
    s.column = 4'd7;
    s.pressed = 1'b1;
    for (int i = 0; i < MAX_THR_RUN; i++) offer(s, 1'b0, '0);
    s.pressed = 1'b0;
    repeat (2) offer(s, 1'b0, '0);

    // Random phases: runs of one level on one key, some bounces, some noise
    for (int phase = 0; phase < 4; phase++) begin
      write_threshold(phase == 0 ? 16'd0 : 16'($urandom_range(1, 6)));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          s = sample_t'(8'($urandom));
          if (s.row < ROWS && s.column < COLUMNS) begin
            if ($urandom_range(0, 1)) s.row = 3'($urandom_range(ROWS, 7));
            else s.column = 4'd15;
          end
          offer(s, 1'b0, '0);
        end else begin
          run_row = 3'($urandom_range(0, ROWS - 1));
          run_col = 4'($urandom_range(0, COLUMNS - 1));
          level   = 1'($urandom);
          bounce  = $urandom_range(0, 2) == 0;
          run_len = $urandom_range(1, int'(threshold) + 3);
          for (int i = 0; i < run_len; i++) begin
            s.row     = run_row;
            s.column  = run_col;
            s.pressed = level ^ (bounce && i == run_len / 2);
            offer(s, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (failures == 0) $display("key_matrix_debouncer regression: pass");
    else $display("key_matrix_debouncer regression: fail");
    $finish;
  end

endmodule

// ----- key_matrix_debouncer.f -----
+incdir+rtl
rtl/kmd_pkg.sv
rtl/kmd_ram.sv
rtl/key_matrix_debouncer.sv
tb/key_matrix_debouncer_tb.sv
